// ===== hw/rtl/dpu_pkg.sv =====
`default_nettype none
package dpu_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAL,
      ST_FLD_LOAD,
      ST_SHIFT,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      KIND_PAL_WRITE = 2'd0,
      KIND_SCAN      = 2'd1,
      KIND_CONVERT   = 2'd2,
      KIND_FRAME     = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_OK    = 2'd0,
      ERR_INDEX = 2'd1,
      ERR_MASK  = 2'd2
   } err_type;

   typedef enum logic [2:0] {
      REG_BPP   = 3'd0,
      REG_RED   = 3'd1,
      REG_GREEN = 3'd2,
      REG_BLUE  = 3'd3,
      REG_ALPHA = 3'd4,
      REG_PSIZE = 3'd5
   } reg_type;

   localparam logic [5:0]  BPP_RESET   = 6'd32;
   localparam logic [31:0] RED_RESET   = 32'h00ff0000;
   localparam logic [31:0] GREEN_RESET = 32'h0000ff00;
   localparam logic [31:0] BLUE_RESET  = 32'h000000ff;
   localparam logic [31:0] ALPHA_RESET = 32'hff000000;
   localparam logic [8:0]  PSIZE_RESET = 9'd0;

endpackage
`default_nettype wire

// ===== hw/rtl/dib_pixel_unpack_unit.sv =====
`default_nettype none
// Bitmap pixel unpacker. Each request carries a kind: palette writes store an
// entry into the palette memory, frame start clears the alpha-seen flag, scan
// requests update that flag and convert requests produce one RGBA result with
// legacy XOR color and an error code. One request is worked at a time.
// Palette writes and frame starts complete at acceptance. Palette pixels pass
// issue, a registered memory read and finish; 24-bit pixels pass issue, finish.
// Bit-field pixels run each of the four masks through a shared unit: a load
// step, one shift per trailing zero of the mask to align it, a step to check
// the run and set up the divider, and 8 steps of a restoring divider for
// the rounded scaling to 0..255; a zero alpha mask is settled in its load step.
// A convert request also waits in its finish state while the previous result
// is still stalled. Results sit in an output register so the next request is
// taken while a result waits.
module dib_pixel_unpack_unit #(
   parameter int PALETTE_DEPTH = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [7:0]  req_entry_index,
   input  wire logic [23:0] req_entry_rgb,
   input  wire logic [31:0] req_pixel_code,
   input  wire logic        req_and_mask_bit,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic [7:0]       rsp_alpha,
   output logic [7:0]       rsp_xor_red,
   output logic [7:0]       rsp_xor_green,
   output logic [7:0]       rsp_xor_blue,
   output logic             rsp_xor_valid,
   output logic [1:0]       rsp_error_code,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

   // Configuration registers.
   logic [5:0]  bpp_ff;
   logic [31:0] red_ff, green_ff, blue_ff, alpha_ff;
   logic [8:0]  psize_ff;

   // Palette memory, with a registered read.
   logic [23:0] pal_mem [PALETTE_DEPTH];
   logic [23:0] pal_rd_ff;

   dpu_pkg::state_type state_ff, state_in;
   logic        alpha_seen_ff;
   logic [1:0]  kind_ff;
   logic [31:0] code_ff;
   logic        masked_ff, deep_ff, bad_ff;
   logic [1:0]  err_ff;
   logic [1:0]  fld_ff;
   logic [31:0] m_ff, w_ff;
   logic [39:0] rem_ff, den_ff;
   logic [7:0]  q_ff;
   logic [2:0]  step_ff;
   logic [7:0]  c_ff [4];

   logic        rsp_valid_ff;
   logic [7:0]  r_ff, g_ff, b_ff, a_ff, xr_ff, xg_ff, xb_ff;
   logic        xv_ff;
   logic [1:0]  ec_ff;

   logic accept, cfg_wr;
   assign accept = req_valid && !req_stall;
   assign cfg_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;

   always_comb begin
      unique case (dpu_pkg::reg_type'(paddr[4:2]))
         dpu_pkg::REG_BPP:   prdata = {26'd0, bpp_ff};
         dpu_pkg::REG_RED:   prdata = red_ff;
         dpu_pkg::REG_GREEN: prdata = green_ff;
         dpu_pkg::REG_BLUE:  prdata = blue_ff;
         dpu_pkg::REG_ALPHA: prdata = alpha_ff;
         dpu_pkg::REG_PSIZE: prdata = {23'd0, psize_ff};
         default:            prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff   <= dpu_pkg::BPP_RESET;
         red_ff   <= dpu_pkg::RED_RESET;
         green_ff <= dpu_pkg::GREEN_RESET;
         blue_ff  <= dpu_pkg::BLUE_RESET;
         alpha_ff <= dpu_pkg::ALPHA_RESET;
         psize_ff <= dpu_pkg::PSIZE_RESET;
      end else if (cfg_wr) begin
         unique case (dpu_pkg::reg_type'(paddr[4:2]))
            dpu_pkg::REG_BPP:   bpp_ff   <= pwdata[5:0];
            dpu_pkg::REG_RED:   red_ff   <= pwdata;
            dpu_pkg::REG_GREEN: green_ff <= pwdata;
            dpu_pkg::REG_BLUE:  blue_ff  <= pwdata;
            dpu_pkg::REG_ALPHA: alpha_ff <= pwdata;
            dpu_pkg::REG_PSIZE: psize_ff <= pwdata[8:0];
            default: ;
         endcase
      end
   end

   // Request classification at acceptance.
   logic        is_pal_class, is_24;
   logic [8:0]  pal_lim;
   logic        idx_bad, masks_bad, pal_wr_ok;
   assign is_pal_class = (bpp_ff <= 6'd8);
   assign is_24        = (bpp_ff == 6'd24);
   assign pal_lim      = (32'(psize_ff) > 32'(PALETTE_DEPTH)) ?
                         9'(PALETTE_DEPTH) : psize_ff;
   assign idx_bad      = (req_pixel_code >= 32'(pal_lim));
   assign pal_wr_ok    = (32'(req_entry_index) < 32'(PALETTE_DEPTH));
   assign masks_bad    = (red_ff == 32'd0) || (green_ff == 32'd0) ||
                         (blue_ff == 32'd0) || ((red_ff & green_ff) != 32'd0) ||
                         ((red_ff & blue_ff) != 32'd0) ||
                         ((green_ff & blue_ff) != 32'd0) ||
                         ((alpha_ff & (red_ff | green_ff | blue_ff)) != 32'd0);

   // Shared field unit: mask selection, alignment and the divider step.
   logic [31:0] fld_mask;
   logic [39:0] rem_init, rem_sub;
   logic        rem_ge;
   always_comb begin
      case (fld_ff)
         2'd0:    fld_mask = red_ff;
         2'd1:    fld_mask = green_ff;
         2'd2:    fld_mask = blue_ff;
         default: fld_mask = alpha_ff;
      endcase
   end
   // Rounded scaling numerator: field * 255 + top / 2.
   assign rem_init = {w_ff, 8'd0} - {8'd0, w_ff} + {9'd0, m_ff[31:1]};
   assign rem_ge   = (rem_ff >= den_ff);
   assign rem_sub  = rem_ff - den_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dpu_pkg::ST_IDLE: begin
            if (accept && (req_kind == dpu_pkg::KIND_SCAN ||
                           req_kind == dpu_pkg::KIND_CONVERT)) begin
               if (is_pal_class)
                  state_in = idx_bad ? dpu_pkg::ST_FINISH : dpu_pkg::ST_PAL;
               else if (is_24 || masks_bad)
                  state_in = dpu_pkg::ST_FINISH;
               else
                  state_in = dpu_pkg::ST_FLD_LOAD;
            end
         end
         dpu_pkg::ST_PAL: state_in = dpu_pkg::ST_FINISH;
         dpu_pkg::ST_FLD_LOAD: begin
            if (fld_mask != 32'd0)
               state_in = dpu_pkg::ST_SHIFT;
            else if (fld_ff == 2'd3)
               state_in = dpu_pkg::ST_FINISH;
         end
         dpu_pkg::ST_SHIFT: begin
            if (m_ff[0]) state_in = dpu_pkg::ST_DIV;
         end
         dpu_pkg::ST_DIV: begin
            if (step_ff == 3'd0)
               state_in = (fld_ff == 2'd3) ? dpu_pkg::ST_FINISH : dpu_pkg::ST_FLD_LOAD;
         end
         dpu_pkg::ST_FINISH: begin
            if (kind_ff != dpu_pkg::KIND_CONVERT || !rsp_valid_ff || !rsp_stall)
               state_in = dpu_pkg::ST_IDLE;
         end
         default: state_in = dpu_pkg::ST_IDLE;
      endcase
   end

   // Control outputs of the sequencer.
   logic rsp_load, scan_done;
   always_comb begin
      req_stall = 1'b1;
      rsp_load  = 1'b0;
      scan_done = 1'b0;
      unique case (state_ff)
         dpu_pkg::ST_IDLE: req_stall = 1'b0;
         dpu_pkg::ST_FINISH: begin
            if (kind_ff == dpu_pkg::KIND_CONVERT)
               rsp_load = !rsp_valid_ff || !rsp_stall;
            else
               scan_done = 1'b1;
         end
         default: ;
      endcase
   end

   // Final color: error zeroing, AND-mask handling and legacy XOR color.
   logic [1:0] err_eff;
   logic [7:0] fr, fg, fb, fa, fxr, fxg, fxb;
   logic       fxv;
   always_comb begin
      err_eff = bad_ff ? dpu_pkg::ERR_MASK : err_ff;
      fr = c_ff[0]; fg = c_ff[1]; fb = c_ff[2]; fa = c_ff[3];
      fxr = 8'd0; fxg = 8'd0; fxb = 8'd0; fxv = 1'b0;
      if (err_eff != dpu_pkg::ERR_OK) begin
         fr = 8'd0; fg = 8'd0; fb = 8'd0; fa = 8'd0;
      end else if (!(deep_ff && alpha_seen_ff)) begin
         if (!masked_ff) begin
            fa = 8'hff;
         end else if ((c_ff[0] | c_ff[1] | c_ff[2]) != 8'd0) begin
            fxr = c_ff[0]; fxg = c_ff[1]; fxb = c_ff[2]; fxv = 1'b1;
            fr = 8'hff; fg = 8'hff; fb = 8'hff; fa = 8'd0;
         end else begin
            fr = 8'd0; fg = 8'd0; fb = 8'd0; fa = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dpu_pkg::ST_IDLE;
         alpha_seen_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept && req_kind == dpu_pkg::KIND_FRAME)
            alpha_seen_ff <= 1'b0;
         else if (scan_done && err_eff == dpu_pkg::ERR_OK && deep_ff && c_ff[3] != 8'd0)
            alpha_seen_ff <= 1'b1;
         if (rsp_load)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
      end
   end

   // Palette memory port.
   always_ff @(posedge clock) begin
      if (accept && req_kind == dpu_pkg::KIND_PAL_WRITE && pal_wr_ok)
         pal_mem[req_entry_index[AW-1:0]] <= req_entry_rgb;
      pal_rd_ff <= pal_mem[req_pixel_code[AW-1:0]];
   end

   // Datapath.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         dpu_pkg::ST_IDLE: begin
            if (accept) begin
               kind_ff   <= req_kind;
               masked_ff <= req_and_mask_bit;
               code_ff   <= (bpp_ff == 6'd16) ? {16'd0, req_pixel_code[15:0]}
                                              : req_pixel_code;
               deep_ff   <= !is_pal_class && !is_24 && !masks_bad && bpp_ff != 6'd16;
               bad_ff    <= 1'b0;
               fld_ff    <= 2'd0;
               err_ff    <= dpu_pkg::ERR_OK;
               c_ff[0]   <= req_pixel_code[23:16];
               c_ff[1]   <= req_pixel_code[15:8];
               c_ff[2]   <= req_pixel_code[7:0];
               c_ff[3]   <= 8'hff;
               if (is_pal_class && idx_bad)
                  err_ff <= dpu_pkg::ERR_INDEX;
               else if (!is_pal_class && !is_24 && masks_bad)
                  err_ff <= dpu_pkg::ERR_MASK;
            end
         end
         dpu_pkg::ST_PAL: begin
            c_ff[0] <= pal_rd_ff[23:16];
            c_ff[1] <= pal_rd_ff[15:8];
            c_ff[2] <= pal_rd_ff[7:0];
            c_ff[3] <= 8'hff;
         end
         dpu_pkg::ST_FLD_LOAD: begin
            m_ff <= fld_mask;
            w_ff <= code_ff & fld_mask;
            if (fld_mask == 32'd0) begin
               // Only alpha may be missing: 255 for 16-bit words, 0 for other widths.
               c_ff[fld_ff] <= deep_ff ? 8'd0 : 8'hff;
               fld_ff       <= fld_ff + 2'd1;
            end
         end
         dpu_pkg::ST_SHIFT: begin
            if (m_ff[0]) begin
               if ((m_ff & (m_ff + 32'd1)) != 32'd0) bad_ff <= 1'b1;
               rem_ff  <= rem_init;
               den_ff  <= {1'b0, m_ff, 7'd0};
               q_ff    <= 8'd0;
               step_ff <= 3'd7;
            end else begin
               m_ff <= {1'b0, m_ff[31:1]};
               w_ff <= {1'b0, w_ff[31:1]};
            end
         end
         dpu_pkg::ST_DIV: begin
            if (rem_ge) rem_ff <= rem_sub;
            den_ff  <= {1'b0, den_ff[39:1]};
            q_ff    <= {q_ff[6:0], rem_ge};
            step_ff <= step_ff - 3'd1;
            if (step_ff == 3'd0) begin
               c_ff[fld_ff] <= {q_ff[6:0], rem_ge};
               fld_ff       <= fld_ff + 2'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         r_ff <= fr; g_ff <= fg; b_ff <= fb; a_ff <= fa;
         xr_ff <= fxr; xg_ff <= fxg; xb_ff <= fxb; xv_ff <= fxv;
         ec_ff <= err_eff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red        = r_ff;
   assign rsp_green      = g_ff;
   assign rsp_blue       = b_ff;
   assign rsp_alpha      = a_ff;
   assign rsp_xor_red    = xr_ff;
   assign rsp_xor_green  = xg_ff;
   assign rsp_xor_blue   = xb_ff;
   assign rsp_xor_valid  = xv_ff;
   assign rsp_error_code = ec_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/dpu_checker.sv =====
`default_nettype none
module dpu_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_red,
   input wire logic [7:0] rsp_green,
   input wire logic [7:0] rsp_blue,
   input wire logic [7:0] rsp_alpha,
   input wire logic       rsp_xor_valid,
   input wire logic [1:0] rsp_error_code
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_red) && $stable(rsp_alpha)
         && $stable(rsp_error_code))
      else $error("result changed while stalled");

   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_error_code != 2'd3)
      else $error("undefined error code");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != 2'd0 |-> rsp_red == 8'd0 && rsp_green == 8'd0 &&
         rsp_blue == 8'd0 && rsp_alpha == 8'd0 && !rsp_xor_valid)
      else $error("error result carries color");

   a_xor_white: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_xor_valid |-> rsp_red == 8'hff && rsp_green == 8'hff &&
         rsp_blue == 8'hff && rsp_alpha == 8'd0)
      else $error("XOR pixel not transparent white");

endmodule

bind dib_pixel_unpack_unit dpu_checker u_dpu_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_red(rsp_red), .rsp_green(rsp_green), .rsp_blue(rsp_blue),
   .rsp_alpha(rsp_alpha), .rsp_xor_valid(rsp_xor_valid),
   .rsp_error_code(rsp_error_code)
);
`default_nettype wire
